FILE: rtl/ccr_pkg.sv
// Shared types and widths for the circle collision resolver.
`timescale 1ns / 1ps
`default_nettype none
package ccr_pkg;

  localparam int MAX_BALLS_DEF = 16;
  localparam int POS_W  = 20;   // Q11.8 positions and velocities
  localparam int RAD_W  = 16;   // Q8.8 radius
  localparam int REST_W = 9;    // Q1.8 restitution
  localparam int IDX_W  = 6;    // ball_index port width

  localparam logic [REST_W-1:0] REST_RESET = REST_W'(256);

  // shared multiplier operand widths
  localparam int MA_W = 41;
  localparam int MB_W = 19;
  localparam int MP_W = MA_W + MB_W;

  // divider and square root widths
  localparam int DIV_NW = 58;
  localparam int DIV_DW = 36;
  localparam int SQ_W   = 36;   // even
  localparam int SQ_RW  = SQ_W / 2;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic [RAD_W-1:0]        r;
  } ball_t;

endpackage
`default_nettype wire

FILE: rtl/ccr_ifs.sv
// Request channel interfaces for balls in and resolved balls out.
`timescale 1ns / 1ps
`default_nettype none
interface ccr_in_if;
  import ccr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x_in;
  logic signed [POS_W-1:0] pos_y_in;
  logic signed [POS_W-1:0] vel_x_in;
  logic signed [POS_W-1:0] vel_y_in;
  logic [RAD_W-1:0]        radius_in;
  logic                    last_in;
  modport source(output valid, pos_x_in, pos_y_in, vel_x_in, vel_y_in, radius_in, last_in,
                 input ready);
  modport sink(input valid, pos_x_in, pos_y_in, vel_x_in, vel_y_in, radius_in, last_in,
               output ready);
endinterface

interface ccr_out_if;
  import ccr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        ball_index;
  logic signed [POS_W-1:0] pos_x_out;
  logic signed [POS_W-1:0] pos_y_out;
  logic signed [POS_W-1:0] vel_x_out;
  logic signed [POS_W-1:0] vel_y_out;
  logic                    dropped;
  logic                    last_out;
  modport source(output valid, ball_index, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                 dropped, last_out, input ready);
  modport sink(input valid, ball_index, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
               dropped, last_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/ccr_mul.sv
// Shared registered signed multiplier.
`timescale 1ns / 1ps
`default_nettype none
module ccr_mul (
  input  wire logic                            clk,
  input  wire logic signed [ccr_pkg::MA_W-1:0] a,
  input  wire logic signed [ccr_pkg::MB_W-1:0] b,
  output      logic signed [ccr_pkg::MP_W-1:0] p
);
  import ccr_pkg::*;

  always_ff @(posedge clk) begin
    p <= MP_W'(a) * MP_W'(b);
  end
endmodule
`default_nettype wire

FILE: rtl/ccr_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ccr_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ccr_pkg::DIV_NW-1:0]  num,
  input  wire logic [ccr_pkg::DIV_DW-1:0]  den,
  output      logic                        done,
  output      logic [ccr_pkg::DIV_NW-1:0]  quot
);
  import ccr_pkg::*;
  localparam int CNT_W = $clog2(DIV_NW);

  logic [DIV_DW:0]   rem;
  logic [DIV_DW-1:0] dv;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIV_DW:0]   shifted;

  assign shifted = {rem[DIV_DW-1:0], quot[DIV_NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dv   <= den;
    end else if (busy) begin
      if (shifted >= {1'b0, dv}) begin
        rem  <= shifted - {1'b0, dv};
        quot <= {quot[DIV_NW-2:0], 1'b1};
      end else begin
        rem  <= shifted;
        quot <= {quot[DIV_NW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ccr_sqrt.sv
// Integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ccr_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ccr_pkg::SQ_W-1:0]   rad,
  output      logic                       done,
  output      logic [ccr_pkg::SQ_RW-1:0]  root
);
  import ccr_pkg::*;

  logic [SQ_W-1:0] x;
  logic [SQ_W-1:0] r;
  logic [SQ_W-1:0] bitm;
  logic [SQ_W-1:0] trial;
  logic            busy;

  assign trial = r + bitm;
  assign root  = r[SQ_RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= rad;
      r    <= '0;
      bitm <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + bitm;
      end else begin
        r <= r >> 1;
      end
      bitm <= bitm >> 2;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/circle_collision_resolver.sv
// Top level: ball buffer, pair sweep sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
// Collects up to MAX_BALLS circles, one request per cycle, into a ball memory
// with one write and one read port. The request carrying last_in starts a
// sweep over every pair i < j; a ball beyond capacity is discarded and flags
// dropped on the whole set. A pair whose circles are apart takes two memory
// reads, a gate on |dx|, |dy| against the radius sum, then the pair step. A
// touching pair runs through the one shared 41x19 multiplier, an 18-step
// square root and the restoring divider, for a push alone or for a push and
// the impulse. After the sweep the balls are emitted in index order, each
// held until taken; the block takes no new ball until the final result is
// taken. Positions and velocities saturate to 20 bits after every update;
// restitution above 256 acts as 256. Restitution is to be written by the
// user only while the block is idle; the block does not enforce it.
module circle_collision_resolver #(
  parameter int MAX_BALLS = ccr_pkg::MAX_BALLS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         restitution_we,
  input  wire logic [ccr_pkg::REST_W-1:0]   restitution_wdata,
  ccr_in_if.sink                            ball_in,
  ccr_out_if.source                         ball_out
);
  import ccr_pkg::*;

  localparam int IW = $clog2(MAX_BALLS);
  localparam int CW = $clog2(MAX_BALLS + 1);

  typedef enum logic [28:0] {
    S_LOAD = 29'd1 << 0,  S_RDA  = 29'd1 << 1,  S_RDB  = 29'd1 << 2,
    S_LDB  = 29'd1 << 3,  S_GATE = 29'd1 << 4,  S_D2A  = 29'd1 << 5,
    S_D2B  = 29'd1 << 6,  S_D2C  = 29'd1 << 7,  S_SQ   = 29'd1 << 8,
    S_PXM  = 29'd1 << 9,  S_PXD  = 29'd1 << 10, S_PXW  = 29'd1 << 11,
    S_PYM  = 29'd1 << 12, S_PYD  = 29'd1 << 13, S_PYW  = 29'd1 << 14,
    S_UPP  = 29'd1 << 15, S_DOT1 = 29'd1 << 16, S_DOT2 = 29'd1 << 17,
    S_DOTC = 29'd1 << 18, S_TD   = 29'd1 << 19, S_TW   = 29'd1 << 20,
    S_IXM  = 29'd1 << 21, S_IXR  = 29'd1 << 22, S_IYR  = 29'd1 << 23,
    S_UPV  = 29'd1 << 24, S_WBA  = 29'd1 << 25, S_WBB  = 29'd1 << 26,
    S_NEXT = 29'd1 << 27, S_ERD  = 29'd1 << 28
  } state_t;

  // emission wait shares S_ERD's neighbours via a flag
  state_t state, state_next;
  logic   emit_wait;

  function automatic logic signed [POS_W-1:0] sat20(input logic signed [41:0] v);
    if (v > 42'sd524287)       return 20'sd524287;
    else if (v < -42'sd524288) return -20'sd524288;
    else                       return v[POS_W-1:0];
  endfunction

  // configuration
  logic [REST_W-1:0] restitution;
  logic [9:0]        e_sum;
  always_ff @(posedge clk) begin
    if (rst) restitution <= REST_RESET;
    else if (restitution_we) restitution <= restitution_wdata;
  end
  assign e_sum = 10'd256 + ((restitution > REST_W'(256)) ? 10'd256 : 10'(restitution));

  // ball memory
  ball_t           mem [MAX_BALLS];
  ball_t           rd_data, wr_data;
  logic [IW-1:0]   ra, wa;
  logic            we;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wr_data;
    rd_data <= mem[ra];
  end

  // sequencer registers
  logic [CW-1:0]           count;
  logic                    ovf;
  logic [IW-1:0]           i, j, k;
  ball_t                   a, b;
  logic signed [POS_W:0]   dx, dy;
  logic [RAD_W:0]          m;
  logic [DIV_DW-1:0]       d2;
  logic [SQ_RW-1:0]        span;
  logic signed [MA_W-1:0]  px, py, ix, iy;
  logic signed [39:0]      dot, tn;
  logic                    div_neg;

  logic in_acc, stored, out_acc;
  logic [CW-1:0] n_new;
  assign ball_in.ready = (state == S_LOAD);
  assign in_acc  = ball_in.valid && ball_in.ready;
  assign stored  = count < CW'(MAX_BALLS);
  assign n_new   = stored ? count + 1'b1 : count;
  assign out_acc = ball_out.valid && ball_out.ready;

  // shared units
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] p;
  logic [MP_W-1:0]        pmag;
  logic [MP_W:0]          rsum;
  logic signed [MA_W-1:0] p_rnd;
  logic [RAD_W+1:0]       ov;
  logic signed [POS_W:0]  rvx, rvy;
  logic [POS_W:0]         adx, ady;
  logic                   hit;

  ccr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_num, div_q;
  logic [DIV_DW-1:0]   div_den;
  logic signed [MA_W-1:0] q_s;
  logic signed [39:0]     q40;

  ccr_div u_div (.clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
                 .done(div_done), .quot(div_q));

  logic             sq_start, sq_done;
  logic [SQ_RW-1:0] sq_root;

  ccr_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .rad(d2), .done(sq_done),
                   .root(sq_root));

  assign pmag  = p[MP_W-1] ? MP_W'(-p) : MP_W'(p);
  assign rsum  = {1'b0, pmag} + (MP_W+1)'(32768);
  assign p_rnd = p[MP_W-1] ? -$signed({1'b0, rsum[55:16]}) : $signed({1'b0, rsum[55:16]});
  assign ov    = (RAD_W+2)'(m) - (RAD_W+2)'(span);
  assign rvx   = (POS_W+1)'(a.vx) - (POS_W+1)'(b.vx);
  assign rvy   = (POS_W+1)'(a.vy) - (POS_W+1)'(b.vy);
  assign adx   = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
  assign ady   = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
  // |dx| or |dy| at or past the radius sum already rules out contact
  assign hit   = (adx < (POS_W+1)'(m)) && (ady < (POS_W+1)'(m)) && !(dx == '0 && dy == '0);
  assign q_s   = div_neg ? -$signed({1'b0, div_q[MA_W-2:0]}) : $signed({1'b0, div_q[MA_W-2:0]});
  assign q40   = $signed({1'b0, div_q[38:0]});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_GATE:  begin mul_a = MA_W'(dx);  mul_b = MB_W'(dx); end
      S_D2A:   begin mul_a = MA_W'(dy);  mul_b = MB_W'(dy); end
      S_D2B:   begin mul_a = MA_W'($signed({1'b0, m})); mul_b = $signed({2'b0, m}); end
      S_PXM:   begin mul_a = MA_W'(dx);  mul_b = $signed({1'b0, ov}); end
      S_PYM:   begin mul_a = MA_W'(dy);  mul_b = $signed({1'b0, ov}); end
      S_UPP:   begin mul_a = MA_W'(rvx); mul_b = MB_W'(dx); end
      S_DOT1:  begin mul_a = MA_W'(rvy); mul_b = MB_W'(dy); end
      S_DOTC:  begin mul_a = MA_W'(dot); mul_b = $signed(MB_W'(e_sum)); end
      S_IXM:   begin mul_a = MA_W'(tn);  mul_b = MB_W'(dx); end
      S_IXR:   begin mul_a = MA_W'(tn);  mul_b = MB_W'(dy); end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  // divider feed: push uses den of twice the distance, impulse uses d2;
  // both round half away
  always_comb begin
    div_start = (state == S_PXD) || (state == S_PYD) || (state == S_TD);
    if (state == S_TD) begin
      div_num = DIV_NW'({pmag, 7'b0}) + DIV_NW'(d2 >> 1);
      div_den = d2;
    end else begin
      div_num = DIV_NW'(pmag) + DIV_NW'(span);
      div_den = DIV_DW'({span, 1'b0});
    end
  end

  assign sq_start = (state == S_D2C) && !(d2 >= DIV_DW'(p));

  // memory port control
  always_comb begin
    we      = 1'b0;
    wa      = i;
    wr_data = a;
    ra      = i;
    case (state)
      S_LOAD: begin
        we      = in_acc && stored;
        wa      = count[IW-1:0];
        wr_data = '{px: ball_in.pos_x_in, py: ball_in.pos_y_in, vx: ball_in.vel_x_in,
                    vy: ball_in.vel_y_in, r: ball_in.radius_in};
      end
      S_WBA:   we = 1'b1;
      S_WBB: begin
        we      = 1'b1;
        wa      = j;
        wr_data = b;
      end
      S_RDB:   ra = j;
      S_ERD:   ra = k;
      default: ra = i;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (in_acc && ball_in.last_in) state_next = (n_new >= CW'(2)) ? S_RDA : S_ERD;
      S_RDA:   state_next = S_RDB;
      S_RDB:   state_next = S_LDB;
      S_LDB:   state_next = S_GATE;
      S_GATE:  state_next = hit ? S_D2A : S_NEXT;
      S_D2A:   state_next = S_D2B;
      S_D2B:   state_next = S_D2C;
      S_D2C:   state_next = (d2 >= DIV_DW'(p)) ? S_NEXT : S_SQ;
      S_SQ:    if (sq_done) state_next = S_PXM;
      S_PXM:   state_next = S_PXD;
      S_PXD:   state_next = S_PXW;
      S_PXW:   if (div_done) state_next = S_PYM;
      S_PYM:   state_next = S_PYD;
      S_PYD:   state_next = S_PYW;
      S_PYW:   if (div_done) state_next = S_UPP;
      S_UPP:   state_next = S_DOT1;
      S_DOT1:  state_next = S_DOT2;
      S_DOT2:  state_next = S_DOTC;
      S_DOTC:  state_next = dot[39] ? S_TD : S_WBA;
      S_TD:    state_next = S_TW;
      S_TW:    if (div_done) state_next = S_IXM;
      S_IXM:   state_next = S_IXR;
      S_IXR:   state_next = S_IYR;
      S_IYR:   state_next = S_UPV;
      S_UPV:   state_next = S_WBA;
      S_WBA:   state_next = S_WBB;
      S_WBB:   state_next = S_NEXT;
      S_NEXT: begin
        if (CW'(j) + 1'b1 < count || CW'(i) + 2'd2 < count) state_next = S_RDA;
        else state_next = S_ERD;
      end
      S_ERD: begin
        if (emit_wait && out_acc && CW'(k) + 1'b1 == count) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      count          <= '0;
      ovf            <= 1'b0;
      emit_wait      <= 1'b0;
      ball_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            count <= n_new;
            if (!stored) ovf <= 1'b1;
          end
        end
        S_ERD: begin
          // read issued on entry, result register loaded next, then held
          if (!emit_wait) begin
            emit_wait <= 1'b1;
          end else if (!ball_out.valid) begin
            ball_out.valid <= 1'b1;
          end else if (out_acc) begin
            ball_out.valid <= 1'b0;
            emit_wait      <= 1'b0;
            if (CW'(k) + 1'b1 == count) begin
              count <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        i <= '0;
        j <= IW'(1);
        k <= '0;
      end
      S_RDB: a <= rd_data;
      S_LDB: begin
        b  <= rd_data;
        dx <= (POS_W+1)'(a.px) - (POS_W+1)'(rd_data.px);
        dy <= (POS_W+1)'(a.py) - (POS_W+1)'(rd_data.py);
        m  <= (RAD_W+1)'(a.r) + (RAD_W+1)'(rd_data.r);
      end
      S_D2A: d2 <= DIV_DW'(p);
      S_D2B: d2 <= d2 + DIV_DW'(p);
      S_SQ:  if (sq_done) span <= sq_root;
      S_PXD, S_PYD: div_neg <= p[MP_W-1];
      S_TD:  div_neg <= p[MP_W-1];
      S_PXW: if (div_done) px <= q_s;
      S_PYW: if (div_done) py <= q_s;
      S_UPP: begin
        a.px <= sat20(42'(a.px) + 42'(px));
        a.py <= sat20(42'(a.py) + 42'(py));
        b.px <= sat20(42'(b.px) - 42'(px));
        b.py <= sat20(42'(b.py) - 42'(py));
      end
      S_DOT1: dot <= 40'(p);
      S_DOT2: dot <= dot + 40'(p);
      S_TW:  if (div_done) tn <= div_neg ? q40 : -q40;   // holds -t
      S_IXR: ix <= p_rnd;
      S_IYR: iy <= p_rnd;
      S_UPV: begin
        a.vx <= sat20(42'(a.vx) + 42'(ix));
        a.vy <= sat20(42'(a.vy) + 42'(iy));
        b.vx <= sat20(42'(b.vx) - 42'(ix));
        b.vy <= sat20(42'(b.vy) - 42'(iy));
      end
      S_NEXT: begin
        if (CW'(j) + 1'b1 < count) begin
          j <= j + 1'b1;
        end else begin
          i <= i + 1'b1;
          j <= i + IW'(2);
        end
      end
      S_ERD: begin
        if (emit_wait && !ball_out.valid) begin
          ball_out.ball_index <= IDX_W'(k);
          ball_out.pos_x_out  <= rd_data.px;
          ball_out.pos_y_out  <= rd_data.py;
          ball_out.vel_x_out  <= rd_data.vx;
          ball_out.vel_y_out  <= rd_data.vy;
          ball_out.dropped    <= ovf;
          ball_out.last_out   <= (CW'(k) + 1'b1 == count);
        end
        if (emit_wait && out_acc) k <= k + 1'b1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb_circle_collision_resolver.sv
// Self-checking testbench for the circle collision resolver.
`timescale 1ns / 1ps
module tb_circle_collision_resolver;
  import ccr_pkg::*;

  localparam int NBALLS = 16;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [POS_W-1:0] px, py, vx, vy;
    logic dropped, last;
  } ball_res_t;

  // Resolved-ball predictor and store of expected results
  class ball_scoreboard;
    longint bpx[NBALLS], bpy[NBALLS], bvx[NBALLS], bvy[NBALLS], brad[NBALLS];
    int count;
    bit overflow;
    int rest;
    ball_res_t pending[$];
    int mismatches;
    int results_seen;
    int sets_done;
    int collisions;

    function new();
      count = 0; overflow = 0; rest = 256; mismatches = 0;
      results_seen = 0; sets_done = 0; collisions = 0;
    endfunction

    function longint sat(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
    endfunction

    // half away from zero, d > 0
    function longint rdiv(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function longint sqrt_floor(longint x);
      longint r, b;
      r = 0; b = longint'(1) <<< 62;
      while (b > x) b = b >>> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b); r = (r >>> 1) + b;
        end else r = r >>> 1;
        b = b >>> 2;
      end
      return r;
    endfunction

    function void resolve(int i, int j, longint e);
      longint dx, dy, m, d2, span, ov, px, py, rvx, rvy, dot, t, ix, iy;
      dx = bpx[i] - bpx[j];
      dy = bpy[i] - bpy[j];
      m = brad[i] + brad[j];
      d2 = dx * dx + dy * dy;
      if (d2 == 0 || d2 >= m * m) return;
      collisions++;
      span = sqrt_floor(d2);
      ov = m - span;
      px = rdiv(dx * ov, 2 * span);
      py = rdiv(dy * ov, 2 * span);
      bpx[i] = sat(bpx[i] + px); bpy[i] = sat(bpy[i] + py);
      bpx[j] = sat(bpx[j] - px); bpy[j] = sat(bpy[j] - py);
      rvx = bvx[i] - bvx[j];
      rvy = bvy[i] - bvy[j];
      dot = rvx * dx + rvy * dy;
      if (dot < 0) begin
        t = rdiv(dot * (256 + e) * 128, d2);
        ix = rdiv(-t * dx, 65536);
        iy = rdiv(-t * dy, 65536);
        bvx[i] = sat(bvx[i] + ix); bvy[i] = sat(bvy[i] + iy);
        bvx[j] = sat(bvx[j] - ix); bvy[j] = sat(bvy[j] - iy);
      end
    endfunction

    // note an accepted ball request
    function void note_ball(logic signed [POS_W-1:0] px, py, vx, vy,
                            logic [RAD_W-1:0] r, logic last);
      longint e;
      ball_res_t b;
      if (count < NBALLS) begin
        bpx[count] = longint'(px); bpy[count] = longint'(py);
        bvx[count] = longint'(vx); bvy[count] = longint'(vy);
        brad[count] = longint'(r);
        count++;
      end else overflow = 1;
      if (!last) return;
      e = (rest > 256) ? 256 : rest;
      for (int i = 0; i < count; i++)
        for (int j = i + 1; j < count; j++) resolve(i, j, e);
      for (int i = 0; i < count; i++) begin
        b.idx = IDX_W'(i);
        b.px = POS_W'(bpx[i]); b.py = POS_W'(bpy[i]);
        b.vx = POS_W'(bvx[i]); b.vy = POS_W'(bvy[i]);
        b.dropped = overflow; b.last = (i + 1 == count);
        pending = {pending, b};
      end
      count = 0; overflow = 0; sets_done++;
    endfunction

    function void check_result(ball_res_t got);
      ball_res_t w;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result index %0d", got.idx);
        return;
      end
      w = pending.pop_front();
      if (got.idx !== w.idx || got.px !== w.px || got.py !== w.py || got.vx !== w.vx ||
          got.vy !== w.vy || got.dropped !== w.dropped || got.last !== w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: exp idx=%0d p=(%0d,%0d) v=(%0d,%0d) d=%0b l=%0b",
                    " got idx=%0d p=(%0d,%0d) v=(%0d,%0d) d=%0b l=%0b"},
                   w.idx, w.px, w.py, w.vx, w.vy, w.dropped, w.last,
                   got.idx, got.px, got.py, got.vx, got.vy, got.dropped, got.last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic restitution_we = 0;
  logic [REST_W-1:0] restitution_wdata = '0;
  longint cycle = 0;

  ccr_in_if ball_in_ch();
  ccr_out_if ball_out_ch();

  ball_scoreboard sb;

  circle_collision_resolver u_dut (
    .clk(clk), .rst(rst),
    .restitution_we(restitution_we), .restitution_wdata(restitution_wdata),
    .ball_in(ball_in_ch.sink), .ball_out(ball_out_ch.source)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    ball_in_ch.valid = 0;
    ball_in_ch.pos_x_in = '0; ball_in_ch.pos_y_in = '0;
    ball_in_ch.vel_x_in = '0; ball_in_ch.vel_y_in = '0;
    ball_in_ch.radius_in = '0; ball_in_ch.last_in = 0;
    ball_out_ch.ready = 0;
  end

  // Timeout: a full set of 16 balls holds 120 pairs
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result sink with random stalls; ready drawn once per result
  int stall_left = 0;
  always @(posedge clk) begin
    ball_res_t got;
    if (!rst) begin
      if (ball_out_ch.valid && ball_out_ch.ready) begin
        got.idx = ball_out_ch.ball_index;
        got.px = ball_out_ch.pos_x_out; got.py = ball_out_ch.pos_y_out;
        got.vx = ball_out_ch.vel_x_out; got.vy = ball_out_ch.vel_y_out;
        got.dropped = ball_out_ch.dropped; got.last = ball_out_ch.last_out;
        sb.check_result(got);
        stall_left = (cycle % 7 < 3) ? 0 : $urandom_range(0, 3);
        ball_out_ch.ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        ball_out_ch.ready <= (stall_left == 0);
      end else ball_out_ch.ready <= 1;
    end
  end

  // Drive one ball request, hold until accepted; valid stays up so that a
  // following request can go out back to back, and is dropped on a gap
  task automatic send_ball(logic signed [POS_W-1:0] px, py, vx, vy,
                           logic [RAD_W-1:0] r, logic last, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      ball_in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    ball_in_ch.valid <= 1;
    ball_in_ch.pos_x_in <= px; ball_in_ch.pos_y_in <= py;
    ball_in_ch.vel_x_in <= vx; ball_in_ch.vel_y_in <= vy;
    ball_in_ch.radius_in <= r; ball_in_ch.last_in <= last;
    do @(posedge clk); while (!ball_in_ch.ready);
    sb.note_ball(px, py, vx, vy, r, last);
  endtask

  task automatic wait_idle();
    ball_in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_restitution(int val);
    wait_idle();
    restitution_we <= 1;
    restitution_wdata <= REST_W'(val);
    @(posedge clk);
    restitution_we <= 0;
    sb.rest = val;
  endtask

  // One set of balls clustered so that many pairs touch
  task automatic send_cluster(int n, bit overfill);
    int cx, cy, spread;
    logic signed [POS_W-1:0] px, py, vx, vy;
    logic [RAD_W-1:0] r;
    bit no_gap;
    cx = $urandom_range(0, 1048575) - 524288;
    cy = $urandom_range(0, 1048575) - 524288;
    spread = (1 << $urandom_range(8, 14));
    no_gap = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          px = POS_W'($urandom); py = POS_W'($urandom);
          vx = POS_W'($urandom); vy = POS_W'($urandom); r = RAD_W'($urandom);
        end
        default: begin
          px = POS_W'(cx + $signed($urandom_range(0, 2 * spread)) - spread);
          py = POS_W'(cy + $signed($urandom_range(0, 2 * spread)) - spread);
          vx = POS_W'($urandom_range(0, 8191) - 4096);
          vy = POS_W'($urandom_range(0, 8191) - 4096);
          r = RAD_W'($urandom_range(spread / 4, spread));
          if ($urandom_range(0, 7) == 0) vx = POS_W'($urandom);
          if ($urandom_range(0, 7) == 0) r = RAD_W'($urandom);
        end
      endcase
      send_ball(px, py, vx, vy, r, k == n - 1, no_gap);
    end
  endtask

  initial begin
    int sent;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, coincident centres, saturation, single ball
    send_ball(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sh80000, 16'hFFFF, 1, 0);
    send_ball(20'sd100, 20'sd100, 20'sd50, 20'sd0, 16'd512, 0, 0);
    send_ball(20'sd100, 20'sd100, -20'sd50, 20'sd0, 16'd512, 1, 0);
    send_ball(20'sh7FF00, 20'sd0, 20'sh7FFFF, 20'sd0, 16'hFFFF, 0, 0);
    send_ball(20'sh7FE00, 20'sd0, 20'sh80000, 20'sd0, 16'hFFFF, 0, 0);
    send_ball(20'sh80000, 20'sh80000, -20'sd300, 20'sd0, 16'd0, 0, 0);
    send_ball(20'sd0, 20'sd0, 20'sd0, 20'sd0, 16'd0, 1, 0);
    set_restitution(0);
    send_ball(20'sd0, 20'sd0, 20'sd256, 20'sd0, 16'd1000, 0, 0);
    send_ball(20'sd1000, 20'sd300, -20'sd256, 20'sd10, 16'd1000, 1, 0);
    set_restitution(511);
    send_ball(20'sd0, 20'sd0, 20'sd256, 20'sd0, 16'd1000, 0, 0);
    send_ball(20'sd1000, 20'sd300, -20'sd256, 20'sd10, 16'd1000, 1, 0);
    // Over capacity: 18 balls, the last two discarded; the last still starts the sweep
    for (int k = 0; k < 18; k++)
      send_ball(POS_W'(k * 4096), 20'sd0, 20'sd0, 20'sd0, 16'd100, k == 17, 0);

    // Random sets, mostly small; occasional full or overfilled sets
    sent = 0;
    while (sent < 320) begin
      int n, pick;
      pick = $urandom_range(0, 9);
      n = (pick == 0) ? $urandom_range(16, 18) : $urandom_range(1, 6);
      if (sent % 80 < 6) set_restitution($urandom_range(0, 511));
      if (sent > 150 && sent < 160) wait_idle();
      send_cluster(n, 0);
      sent += n;
    end
    set_restitution(256);
    send_cluster(3, 0);

    wait_idle();
    $display("Covered %0d ball sets, %0d results, %0d touching pairs, restitution 0..511.",
             sb.sets_done, sb.results_seen, sb.collisions);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
